@@ rtl/cdpa_pkg.sv @@
package cdpa_pkg;

   // Calendar limits
   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [3:0]  MONTHS      = 4'd12;
   localparam logic [4:0]  DAYS_LONG   = 5'd31;
   localparam logic [4:0]  DAYS_SHORT  = 5'd30;
   localparam logic [4:0]  DAYS_FEB    = 5'd28;
   localparam logic [4:0]  DAYS_FEB_LP = 5'd29;

   // Divisibility by 25: multiply by the inverse of 25 modulo 2^14 and
   // compare against floor((2^14 - 1) / 25)
   localparam logic [13:0] DIV25_INV   = 14'd7209;
   localparam logic [13:0] DIV25_LIMIT = 14'd655;

   // Datapath actions driven by the control store
   typedef enum logic [3:0] {
      DP_NONE,
      DP_CAPTURE,
      DP_LOAD_YM,
      DP_LOAD_D,
      DP_ADD_D,
      DP_DAY_STEP,
      DP_ADD_M,
      DP_ADD_Y,
      DP_EMIT
   } cdpa_dp_type;

   // Status from the datapath, tested by the sequencer's branches
   typedef struct packed {
      logic accept;
      logic is_add;
      logic day_over;
      logic out_free;
   } cdpa_flags_type;

   // Decoded micro-operation handed to the datapath
   typedef struct packed {
      cdpa_dp_type op;
      logic        idle;
   } cdpa_uop_type;

   // Days in a month, February from the leap flag
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:    len = leap ? DAYS_FEB_LP : DAYS_FEB;
         4'd4:    len = DAYS_SHORT;
         4'd6:    len = DAYS_SHORT;
         4'd9:    len = DAYS_SHORT;
         4'd11:   len = DAYS_SHORT;
         default: len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/cdpa_seq.sv @@
module cdpa_seq
   import cdpa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cdpa_flags_type flags,
   output cdpa_uop_type   uop
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LOAD_YM,
      S_LOAD_WAIT,
      S_LOAD_D,
      S_ADD_D,
      S_DAY_LOOP,
      S_ADD_M,
      S_ADD_Y,
      S_EMIT
   } step_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_ACCEPT,
      C_IS_ADD,
      C_DAY_OVER,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      cdpa_dp_type op;
      cond_type    cond;
      step_type    on_true;
      step_type    on_false;
   } ctrl_type;

   step_type step_ff, step_in;
   ctrl_type ctrl;
   logic     taken;

   // Control store: one word per step
   function automatic ctrl_type ucode(input step_type s);
      ctrl_type w;
      case (s)
         S_IDLE:      w = '{DP_CAPTURE,  C_ACCEPT,   S_DISPATCH,  S_IDLE};
         S_DISPATCH:  w = '{DP_NONE,     C_IS_ADD,   S_ADD_D,     S_LOAD_YM};
         S_LOAD_YM:   w = '{DP_LOAD_YM,  C_ALWAYS,   S_LOAD_WAIT, S_LOAD_WAIT};
         S_LOAD_WAIT: w = '{DP_NONE,     C_ALWAYS,   S_LOAD_D,    S_LOAD_D};
         S_LOAD_D:    w = '{DP_LOAD_D,   C_ALWAYS,   S_EMIT,      S_EMIT};
         S_ADD_D:     w = '{DP_ADD_D,    C_ALWAYS,   S_DAY_LOOP,  S_DAY_LOOP};
         S_DAY_LOOP:  w = '{DP_DAY_STEP, C_DAY_OVER, S_DAY_LOOP,  S_ADD_M};
         S_ADD_M:     w = '{DP_ADD_M,    C_ALWAYS,   S_ADD_Y,     S_ADD_Y};
         S_ADD_Y:     w = '{DP_ADD_Y,    C_ALWAYS,   S_EMIT,      S_EMIT};
         S_EMIT:      w = '{DP_EMIT,     C_OUT_FREE, S_IDLE,      S_EMIT};
         default:     w = '{DP_NONE,     C_ALWAYS,   S_IDLE,      S_IDLE};
      endcase
      return w;
   endfunction

   // Fetch the word and resolve its branch
   always_comb begin
      ctrl = ucode(step_ff);
      case (ctrl.cond)
         C_ALWAYS:   taken = 1'b1;
         C_ACCEPT:   taken = flags.accept;
         C_IS_ADD:   taken = flags.is_add;
         C_DAY_OVER: taken = flags.day_over;
         C_OUT_FREE: taken = flags.out_free;
         default:    taken = 1'b1;
      endcase
      step_in  = taken ? ctrl.on_true : ctrl.on_false;
      uop.op   = ctrl.op;
      uop.idle = (step_ff == S_IDLE);
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/calendar_date_period_adder_top.sv @@
// Gregorian date register with a period adder.
//
// req channel: one transaction per item. req_tuser is the operation
// (0 = load the date, 1 = add the period). A load stores year, month and day,
// clamped into range; an add applies days, then months, then years.
// rsp channel: one transaction per item carrying the stored date after it;
// rsp_tuser is raised when a year step passed 9999 and the year was held.
//
// A load runs the load steps and then the emit step. An add runs the day loop,
// where the sequencer retires one month per cycle for each month end crossed by
// the added days (at most about 136), then the month, year and emit steps. The
// next request is taken once the result sits in the output register, so each
// item completes before the next one is accepted.
//
// Reset (synchronous) sets the date to 1 January of year 1 and empties the
// output register. While rsp_tready is low a finished result is held in the
// output register and the next item waits in its final step.
module calendar_date_period_adder_top
   import cdpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // load_year, load_month, load_day, add_years, add_months, add_days, zero fill
   input  logic [55:0] req_tdata,
   // op
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cur_year, cur_month, cur_day, zero fill
   output logic [23:0] rsp_tdata,
   // year_saturated
   output logic        rsp_tuser
);

   cdpa_flags_type flags;
   cdpa_uop_type   uop;

   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [12:0] day_ff, day_in;
   logic        leap_ff, leap_in;
   logic        sat_ff, sat_in;

   logic        op_ff, op_in;
   logic [13:0] ld_year_ff, ld_year_in;
   logic [3:0]  ld_month_ff, ld_month_in;
   logic [4:0]  ld_day_ff, ld_day_in;
   logic [13:0] ay_ff, ay_in;
   logic [3:0]  am_ff, am_in;
   logic [11:0] ad_ff, ad_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   logic        accept;
   logic        out_free;
   logic [4:0]  mon_len;
   logic        day_over;
   logic [13:0] div25_prod;
   logic        div25;
   logic [14:0] year_inc;
   logic [13:0] year_inc_sat;
   logic        year_inc_over;
   logic [4:0]  month_sum;
   logic [14:0] year_sum;
   logic [3:0]  req_month;

   cdpa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uop   (uop)
   );

   assign req_tready = uop.idle;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Month length and loop test
   assign mon_len  = month_len(month_ff, leap_ff);
   assign day_over = day_ff > {8'd0, mon_len};

   // Leap rule: divisible by 4 and not by 100, or divisible by 400
   assign div25_prod = year_ff * DIV25_INV;
   assign div25      = div25_prod <= DIV25_LIMIT;
   assign leap_in    = (year_ff[1:0] == 2'd0) && (!div25 || (year_ff[3:0] == 4'd0));

   // Saturating year increment for month wraps
   assign year_inc      = {1'b0, year_ff} + 15'd1;
   assign year_inc_over = year_inc > {1'b0, YEAR_MAX};
   assign year_inc_sat  = year_inc_over ? YEAR_MAX : year_inc[13:0];

   assign month_sum = {1'b0, month_ff} + {1'b0, am_ff};
   assign year_sum  = {1'b0, year_ff} + {1'b0, ay_ff};
   assign req_month = req_tdata[40:37];

   assign flags.accept   = accept;
   assign flags.is_add   = op_ff;
   assign flags.day_over = day_over;
   assign flags.out_free = out_free;

   // Datapath: carry out the action of the current step
   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      sat_in       = sat_ff;
      op_in        = op_ff;
      ld_year_in   = ld_year_ff;
      ld_month_in  = ld_month_ff;
      ld_day_in    = ld_day_ff;
      ay_in        = ay_ff;
      am_in        = am_ff;
      ad_in        = ad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (uop.op)
         DP_CAPTURE: begin
            if (accept) begin
               op_in       = req_tuser;
               ld_year_in  = req_tdata[13:0];
               ld_month_in = req_tdata[17:14];
               ld_day_in   = req_tdata[22:18];
               ay_in       = req_tdata[36:23];
               am_in       = (req_month >= MONTHS) ? req_month - MONTHS : req_month;
               ad_in       = req_tdata[52:41];
            end
         end
         DP_LOAD_YM: begin
            sat_in = 1'b0;
            if (ld_year_ff == 14'd0) begin
               year_in = 14'd1;
            end else if (ld_year_ff > YEAR_MAX) begin
               year_in = YEAR_MAX;
            end else begin
               year_in = ld_year_ff;
            end
            if (ld_month_ff == 4'd0) begin
               month_in = 4'd1;
            end else if (ld_month_ff > MONTHS) begin
               month_in = MONTHS;
            end else begin
               month_in = ld_month_ff;
            end
         end
         DP_LOAD_D: begin
            if (ld_day_ff == 5'd0) begin
               day_in = 13'd1;
            end else if (ld_day_ff > mon_len) begin
               day_in = {8'd0, mon_len};
            end else begin
               day_in = {8'd0, ld_day_ff};
            end
         end
         DP_ADD_D: begin
            sat_in = 1'b0;
            day_in = day_ff + {1'b0, ad_ff};
         end
         DP_DAY_STEP: begin
            // Take off one month length and move to the next month
            if (day_over) begin
               day_in = day_ff - {8'd0, mon_len};
               if (month_ff >= MONTHS) begin
                  month_in = 4'd1;
                  year_in  = year_inc_sat;
                  sat_in   = sat_ff || year_inc_over;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end
         DP_ADD_M: begin
            if (month_sum > {1'b0, MONTHS}) begin
               month_in = month_sum[3:0] - MONTHS;
               year_in  = year_inc_sat;
               sat_in   = sat_ff || year_inc_over;
            end else begin
               month_in = month_sum[3:0];
            end
         end
         DP_ADD_Y: begin
            if (year_sum > {1'b0, YEAR_MAX}) begin
               year_in = YEAR_MAX;
               sat_in  = 1'b1;
            end else begin
               year_in = year_sum[13:0];
            end
         end
         DP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, day_ff[4:0], month_ff, year_ff};
               rsp_user_in  = sat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold date, operands and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff      <= 14'd1;
         month_ff     <= 4'd1;
         day_ff       <= 13'd1;
         leap_ff      <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         leap_ff      <= leap_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ld_year_ff  <= ld_year_in;
      ld_month_ff <= ld_month_in;
      ld_day_ff   <= ld_day_in;
      ay_ff       <= ay_in;
      am_ff       <= am_in;
      ad_ff       <= ad_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Drop ready for the cycle after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // Between items the stored date is a proper day and month
   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (day_ff >= 13'd1 && day_ff <= 13'd31 &&
                      month_ff >= 4'd1 && month_ff <= MONTHS))
      else $error("stored day or month out of range while idle");

   // Year stays within the calendar
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      year_ff >= 14'd1 && year_ff <= YEAR_MAX)
      else $error("year out of range");

   // A saturation flag comes only with the held maximum year
   a_sat_year: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[13:0] == YEAR_MAX))
      else $error("saturation flagged below the maximum year");

endmodule

@@ tb/tb_calendar_date_period_adder_top.sv @@
module tb_calendar_date_period_adder_top
   import cdpa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 1_500_000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS     = 1500;
   localparam int DRAIN_CYCLES     = 200;

   localparam int unsigned YEAR_TOP    = 32'(YEAR_MAX);
   localparam int unsigned MONTH_COUNT = 32'(MONTHS);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_ADD  = 1'b1
   } date_op_type;

   typedef struct packed {
      date_op_type op;
      logic [13:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [13:0] add_years;
      logic [3:0]  add_months;
      logic [11:0] add_days;
   } period_item_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        sat;
   } date_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // load_year, load_month, load_day, add_years, add_months, add_days, zero fill
   logic [55:0] req_tdata = '0;
   // op
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // cur_year, cur_month, cur_day, zero fill
   logic [23:0] rsp_tdata;
   // year_saturated
   logic        rsp_tuser;

   // Calendar state of the predictor
   logic [13:0] cal_year;
   logic [3:0]  cal_month;
   logic [12:0] cal_day;
   logic        cal_sat;

   date_result_type expected_dates[$];

   int mismatch_count = 0;
   int loads_sent     = 0;
   int adds_sent      = 0;
   int held_years     = 0;
   int burst_left     = 0;
   int hold_asks      = 0;
   int hold_seen      = 0;
   int cycles_run     = 0;

   calendar_date_period_adder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Calendar arithmetic of the predictor

   function automatic bit is_leap(input logic [13:0] y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
   endfunction

   function automatic int unsigned days_in_month(input logic [13:0] y, input logic [3:0] m);
      if (m == 4'd2) begin
         return is_leap(y) ? 29 : 28;
      end
      if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
         return 30;
      end
      return 31;
   endfunction

   // Add years, holding at the top year and flagging it
   function automatic void step_year(input int unsigned n);
      int unsigned sum;
      sum = 32'(cal_year) + n;
      if (sum > YEAR_TOP) begin
         sum = YEAR_TOP;
         cal_sat = 1'b1;
      end
      cal_year = sum[13:0];
   endfunction

   // Add months, carrying one year on a wrap
   function automatic void step_month(input int unsigned n);
      int unsigned sum;
      sum = 32'(cal_month) + n;
      if (sum > MONTH_COUNT) begin
         sum = sum - MONTH_COUNT;
         step_year(1);
      end
      cal_month = sum[3:0];
   endfunction

   function automatic date_result_type advance_calendar(input period_item_type it);
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned len;
      date_result_type r;
      cal_sat = 1'b0;
      if (it.op == OP_LOAD) begin
         y = 32'(it.load_year);
         m = 32'(it.load_month);
         d = 32'(it.load_day);
         if (y == 0) y = 1;
         if (y > YEAR_TOP) y = YEAR_TOP;
         if (m == 0) m = 1;
         if (m > MONTH_COUNT) m = MONTH_COUNT;
         len = days_in_month(y[13:0], m[3:0]);
         if (d == 0) d = 1;
         if (d > len) d = len;
         cal_year  = y[13:0];
         cal_month = m[3:0];
         cal_day   = d[12:0];
      end else begin
         // Days first, one month length at a time
         d = 32'(cal_day) + 32'(it.add_days);
         while (d > days_in_month(cal_year, cal_month)) begin
            d = d - days_in_month(cal_year, cal_month);
            step_month(1);
         end
         cal_day = d[12:0];
         step_month(32'(it.add_months) % 12);
         step_year(32'(it.add_years));
      end
      r.year  = cal_year;
      r.month = cal_month;
      r.day   = cal_day[4:0];
      r.sat   = cal_sat;
      return r;
   endfunction

   // Item builders; the fields an operation ignores carry random bits

   function automatic period_item_type make_load(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
      period_item_type it;
      it.op         = OP_LOAD;
      it.load_year  = y[13:0];
      it.load_month = m[3:0];
      it.load_day   = d[4:0];
      it.add_years  = 14'($urandom_range(0, 16383));
      it.add_months = 4'($urandom_range(0, 15));
      it.add_days   = 12'($urandom_range(0, 4095));
      return it;
   endfunction

   function automatic period_item_type make_add(input int unsigned ay, input int unsigned am,
                                                input int unsigned ad);
      period_item_type it;
      it.op         = OP_ADD;
      it.load_year  = 14'($urandom_range(0, 16383));
      it.load_month = 4'($urandom_range(0, 15));
      it.load_day   = 5'($urandom_range(0, 31));
      it.add_years  = ay[13:0];
      it.add_months = am[3:0];
      it.add_days   = ad[11:0];
      return it;
   endfunction

   // Offer one transaction, hold it until taken and record its result
   task automatic send_item(input period_item_type it);
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {3'b000, it.add_days, it.add_months, it.add_years,
                     it.load_day, it.load_month, it.load_year};
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_dates.push_back(advance_calendar(it));
      if (it.op == OP_LOAD) loads_sent++;
      else adds_sent++;
      if (cal_sat) held_years++;
   endtask

   // Drop valid and let the sender idle
   task automatic pause_sender(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Send in bursts of random length with gaps between them
   task automatic offer_item(input period_item_type it);
      send_item(it);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         pause_sender($urandom_range(1, 8));
      end
   endtask

   // Receiver: random stall modes, plus a long hold on request
   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
            hold_seen++;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : rsp_checker
      date_result_type got;
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.year  = rsp_tdata[13:0];
         got.month = rsp_tdata[17:14];
         got.day   = rsp_tdata[22:18];
         got.sat   = rsp_tuser;
         if (expected_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result %0d-%0d-%0d held %0b", got.year, got.month,
                        got.day, got.sat);
            end
         end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year || got.month !== want.month ||
                got.day !== want.day || got.sat !== want.sat) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("date mismatch: expected %0d-%0d-%0d held %0b, got %0d-%0d-%0d held %0b",
                           want.year, want.month, want.day, want.sat,
                           got.year, got.month, got.day, got.sat);
               end
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Date after reset must be 1 January of year 1
   task automatic test_reset_date();
      offer_item(make_add(0, 0, 0));
   endtask

   // Out-of-range load fields are pulled into range
   task automatic test_load_clamping();
      offer_item(make_load(0, 0, 0));
      offer_item(make_load(16383, 15, 31));
      offer_item(make_load(2001, 2, 31));
      offer_item(make_load(2000, 2, 30));
      offer_item(make_load(2023, 4, 31));
   endtask

   // Century and 400-year leap rules
   task automatic test_leap_years();
      offer_item(make_load(1900, 2, 28));
      offer_item(make_add(0, 0, 1));
      offer_item(make_load(2000, 2, 28));
      offer_item(make_add(0, 0, 1));
      offer_item(make_load(2024, 2, 28));
      offer_item(make_add(0, 0, 1));
   endtask

   // Month and year wrap, month field above eleven, unclamped day
   task automatic test_month_and_year_wrap();
      offer_item(make_load(2023, 12, 31));
      offer_item(make_add(0, 0, 1));
      offer_item(make_add(0, 11, 0));
      offer_item(make_add(0, 15, 0));
      offer_item(make_load(2023, 1, 31));
      offer_item(make_add(0, 1, 0));
      offer_item(make_add(0, 0, 0));
   endtask

   // Year held at the top in every stage
   task automatic test_year_saturation();
      offer_item(make_load(9999, 12, 31));
      offer_item(make_add(0, 0, 1));
      offer_item(make_add(16383, 0, 0));
      offer_item(make_add(0, 11, 4095));
      offer_item(make_load(1, 1, 1));
      offer_item(make_add(9998, 0, 0));
      offer_item(make_add(1, 0, 0));
   endtask

   // Hold the receiver off while items keep coming
   task automatic test_output_backpressure();
      int i;
      hold_asks++;
      for (i = 0; i < 12; i++) begin
         offer_item(make_add($urandom_range(0, 3), $urandom_range(0, 15),
                             $urandom_range(0, 200)));
      end
   endtask

   // Random loads and adds, biased towards leap centuries and the top year
   task automatic test_random_periods();
      int i;
      int unsigned y;
      int unsigned ad;
      int unsigned ay;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 20) begin
            if ($urandom_range(0, 3) == 0) begin
               offer_item(make_load($urandom_range(0, 16383), $urandom_range(0, 15),
                                    $urandom_range(0, 31)));
            end else begin
               case ($urandom_range(0, 3))
                  0: y = 9990 + $urandom_range(0, 9);
                  1: y = 100 * (16 + $urandom_range(0, 9)) - $urandom_range(0, 2);
                  2: y = $urandom_range(1, 40);
                  default: y = $urandom_range(1, 9999);
               endcase
               offer_item(make_load(y, $urandom_range(1, 12), $urandom_range(1, 31)));
            end
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: ad = $urandom_range(0, 40);
               6, 7, 8: ad = $urandom_range(0, 400);
               default: ad = $urandom_range(0, 4095);
            endcase
            case ($urandom_range(0, 19))
               0: ay = $urandom_range(0, 16383);
               1, 2: ay = $urandom_range(0, 300);
               default: ay = $urandom_range(0, 5);
            endcase
            offer_item(make_add(ay, $urandom_range(0, 15), ad));
         end
      end
   endtask

   // Main sequence
   initial begin : main_sequence
      cal_year  = 14'd1;
      cal_month = 4'd1;
      cal_day   = 13'd1;
      cal_sat   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_date();
      test_load_clamping();
      test_leap_years();
      test_month_and_year_wrap();
      test_year_saturation();
      test_output_backpressure();
      test_random_periods();

      // Drain outstanding results, then let the block settle
      pause_sender(1);
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d loads and %0d adds, %0d of them with the year held at the top.",
               loads_sent, adds_sent, held_years);
      $display("Receiver held off %0d time(s) for %0d cycles; %0d mismatches.",
               hold_seen, LONG_HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0 && expected_dates.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
